FILE: hdl/rvmie_pkg.sv
// ----------------------------------------------------------------------------
// rvmie_pkg
// Shared types and codes of the register machine instruction executor.
// ----------------------------------------------------------------------------
package rvmie_pkg;

   typedef enum logic [4:0] {
      OP_HLT  = 5'd0,  OP_MOV = 5'd1,  OP_ST  = 5'd2,  OP_LD  = 5'd3,
      OP_ADD  = 5'd4,  OP_SUB = 5'd5,  OP_MUL = 5'd6,  OP_DIV = 5'd7,
      OP_INC  = 5'd8,  OP_DEC = 5'd9,  OP_IN  = 5'd10, OP_OUT = 5'd11,
      OP_POP  = 5'd12, OP_PUSH = 5'd13, OP_CMP = 5'd14, OP_JMP = 5'd15,
      OP_JE   = 5'd16, OP_JNE = 5'd17, OP_JG  = 5'd18, OP_JL  = 5'd19,
      OP_JGE  = 5'd20, OP_JLE = 5'd21
   } opcode_type;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_OPCODE = 2'd1;
   localparam logic [1:0] ERR_DIVZ   = 2'd2;

   typedef struct packed {
      logic capture;
      logic read_ops;
      logic div_start;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic div_zero;
      logic div_done;
      logic is_div;
      logic is_mem;
   } stat_type;

endpackage

FILE: hdl/rvmie_ram.sv
// ----------------------------------------------------------------------------
// rvmie_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rvmie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: hdl/rvmie_ctrl.sv
// ----------------------------------------------------------------------------
// rvmie_ctrl
// Sequencer: clear pass, operand read, memory or divide wait, commit, output.
// ----------------------------------------------------------------------------
module rvmie_ctrl #(
   parameter int CLEAR_CYCLES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rvmie_pkg::stat_type   stat,
   output rvmie_pkg::ctrl_type   ctrl,
   output logic                  clearing,
   output logic [$clog2(CLEAR_CYCLES)-1:0] clear_addr
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_MEM, S_DIV, S_COMMIT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [$clog2(CLEAR_CYCLES)-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign clearing   = (state_ff == S_CLEAR);
   assign clear_addr = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ($clog2(CLEAR_CYCLES))'(CLEAR_CYCLES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl.capture = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctrl.read_ops = 1'b1;
            if (stat.is_mem) begin
               state_in = S_MEM;
            end else if (stat.is_div) begin
               state_in = S_DIV;
               ctrl.div_start = 1'b1;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_MEM: state_in = S_COMMIT;
         S_DIV: begin
            if (stat.div_zero || stat.div_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ctrl.commit = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_tvalid) else $error("Commit not followed by a response.");
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("Accepting while a response waits.");
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready) else $error("Accepting during the clear pass.");
endmodule

FILE: hdl/rvmie_dp.sv
// ----------------------------------------------------------------------------
// rvmie_dp
// Datapath: registers, compare result, label table, data memory and divider.
// ----------------------------------------------------------------------------
module rvmie_dp #(
   parameter int REG_COUNT   = 16,
   parameter int DATA_WORDS  = 1024,
   parameter int CODE_WORDS  = 1024,
   parameter int LABEL_COUNT = 256,
   parameter int WORD_BITS   = 32,
   parameter int CLR_BITS    = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  rvmie_pkg::ctrl_type ctrl,
   output rvmie_pkg::stat_type stat,
   input  logic                clearing,
   input  logic [CLR_BITS-1:0] clear_addr,
   input  logic                command,
   input  logic [4:0]          opcode,
   input  logic [7:0]          dest_or_label,
   input  logic                src_is_const,
   input  logic [31:0]         second_operand,
   input  logic                third_is_reg,
   input  logic [3:0]          third_operand,
   input  logic [31:0]         input_value,
   input  logic [7:0]          label_id,
   input  logic [9:0]          label_target,
   output logic [9:0]          next_pc,
   output logic                halted,
   output logic                out_valid,
   output logic [31:0]         out_value,
   output logic [1:0]          error_code
);
   localparam int RB = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int DB = $clog2(DATA_WORDS);
   localparam int CB = $clog2(CODE_WORDS);
   localparam int LB = $clog2(LABEL_COUNT);
   localparam int W  = WORD_BITS;
   localparam int CW = (W < 32) ? W : 32;

   logic        cmd_ff, src_c_ff, third_r_ff;
   logic [4:0]  op_ff;
   logic [7:0]  first_ff, lid_ff;
   logic [31:0] sec_ff, inval_ff;
   logic [3:0]  third_ff;
   logic [9:0]  ltgt_ff;

   logic [W-1:0] regs_ff [REG_COUNT];
   logic [W-1:0] cmp_ff;
   logic [CB-1:0] pc_ff;
   logic [W-1:0] a_ff, b_ff, d_ff;
   logic [CB-1:0] lab_rd;
   logic [W-1:0]  mem_rd;

   logic [RB-1:0] r0, r1, r2;
   assign r0 = RB'(first_ff % REG_COUNT);
   assign r1 = RB'(sec_ff % REG_COUNT);
   assign r2 = RB'(third_ff % REG_COUNT);

   assign stat.is_mem = !cmd_ff && (op_ff == rvmie_pkg::OP_LD || op_ff == rvmie_pkg::OP_ST);
   assign stat.is_div = !cmd_ff && (op_ff == rvmie_pkg::OP_DIV);

   // Address: base plus optional index, modulo the memory size.
   logic [W-1:0]  addr_sum;
   logic [DB-1:0] maddr;
   logic          mem_we;
   logic [W-1:0]  mem_wd;
   assign addr_sum = regs_ff[r1] + (third_r_ff ? regs_ff[r2] : '0);

   always_comb begin
      if (clearing) begin
         maddr  = DB'(clear_addr);
         mem_we = 1'b1;
         mem_wd = '0;
      end else begin
         maddr  = DB'(addr_sum % DATA_WORDS);
         mem_we = ctrl.commit && !cmd_ff && op_ff == rvmie_pkg::OP_ST;
         mem_wd = d_ff;
      end
   end

   rvmie_ram #(.WIDTH(W), .DEPTH(DATA_WORDS)) u_dmem (
      .clock(clock), .wr_en(mem_we), .addr(maddr), .wr_data(mem_wd), .rd_data(mem_rd));

   logic [LB-1:0] laddr;
   logic          lwe;
   logic [CB-1:0] lwd;
   always_comb begin
      if (clearing) begin
         laddr = LB'(clear_addr);
         lwe   = 1'b1;
         lwd   = '0;
      end else begin
         laddr = ctrl.commit ? LB'(lid_ff % LABEL_COUNT) : LB'(first_ff % LABEL_COUNT);
         lwe   = ctrl.commit && cmd_ff;
         lwd   = CB'(ltgt_ff % CODE_WORDS);
      end
   end

   rvmie_ram #(.WIDTH(CB), .DEPTH(LABEL_COUNT)) u_labels (
      .clock(clock), .wr_en(lwe), .addr(laddr), .wr_data(lwd), .rd_data(lab_rd));

   // Restoring divider on magnitudes, one quotient bit per cycle.
   localparam int KB = $clog2(W + 1);
   logic [W-1:0] dq_ff, dr_ff, dd_ff;
   logic [KB-1:0] dk_ff;
   logic         dneg_ff, dbusy_ff;
   logic [W:0]   trial;
   logic [W-1:0] rem_sh;
   assign rem_sh = {dr_ff[W-2:0], dq_ff[W-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, dd_ff};
   assign stat.div_zero = (b_ff == '0);
   assign stat.div_done = dbusy_ff && (dk_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (ctrl.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (stat.div_done || ctrl.commit) begin
         dbusy_ff <= 1'b0;
      end
      if (ctrl.div_start) begin
         dq_ff   <= regs_ff[r1][W-1] ? -regs_ff[r1] : regs_ff[r1];
         dd_ff   <= regs_ff[r2][W-1] ? -regs_ff[r2] : regs_ff[r2];
         dr_ff   <= '0;
         dk_ff   <= KB'(W);
         dneg_ff <= regs_ff[r1][W-1] ^ regs_ff[r2][W-1];
      end else if (dbusy_ff && dk_ff != '0) begin
         dk_ff <= dk_ff - 1'b1;
         if (!trial[W]) begin
            dr_ff <= trial[W-1:0];
            dq_ff <= {dq_ff[W-2:0], 1'b1};
         end else begin
            dr_ff <= rem_sh;
            dq_ff <= {dq_ff[W-2:0], 1'b0};
         end
      end
   end

   // Capture and operand read.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= command; op_ff <= opcode; first_ff <= dest_or_label;
         src_c_ff <= src_is_const; sec_ff <= second_operand;
         third_r_ff <= third_is_reg; third_ff <= third_operand;
         inval_ff <= input_value; lid_ff <= label_id; ltgt_ff <= label_target;
      end
      if (ctrl.read_ops) begin
         a_ff <= regs_ff[r1];
         b_ff <= regs_ff[r2];
         d_ff <= regs_ff[r0];
      end
   end

   // Commit.
   logic [W-1:0]  wval;
   logic          wen, take, isj, zc, nc;
   logic [CB-1:0] npc, seq;
   logic [1:0]    err;
   logic [W-1:0]  sx_sec, sx_in;
   assign sx_sec = W'($signed(sec_ff[CW-1:0]));
   assign sx_in  = W'($signed(inval_ff[CW-1:0]));
   assign seq = CB'((pc_ff + 1'b1) % CODE_WORDS);
   assign zc = (cmp_ff == '0);
   assign nc = cmp_ff[W-1];

   always_comb begin
      wval = '0; wen = 1'b0; take = 1'b0; isj = 1'b0; err = rvmie_pkg::ERR_NONE;
      npc = seq;
      case (op_ff)
         rvmie_pkg::OP_HLT: npc = pc_ff;
         rvmie_pkg::OP_MOV: begin wen = 1'b1; wval = src_c_ff ? sx_sec : a_ff; end
         rvmie_pkg::OP_ST:  ;
         rvmie_pkg::OP_LD:  begin wen = 1'b1; wval = mem_rd; end
         rvmie_pkg::OP_ADD: begin wen = 1'b1; wval = a_ff + b_ff; end
         rvmie_pkg::OP_SUB: begin wen = 1'b1; wval = a_ff - b_ff; end
         rvmie_pkg::OP_MUL: begin wen = 1'b1; wval = W'(a_ff * b_ff); end
         rvmie_pkg::OP_DIV: begin
            if (b_ff == '0) begin
               err = rvmie_pkg::ERR_DIVZ; npc = pc_ff;
            end else begin
               wen = 1'b1; wval = dneg_ff ? -dq_ff : dq_ff;
            end
         end
         rvmie_pkg::OP_INC: begin wen = 1'b1; wval = d_ff + 1'b1; end
         rvmie_pkg::OP_DEC: begin wen = 1'b1; wval = d_ff - 1'b1; end
         rvmie_pkg::OP_IN:  begin wen = 1'b1; wval = sx_in; end
         rvmie_pkg::OP_OUT, rvmie_pkg::OP_POP, rvmie_pkg::OP_PUSH, rvmie_pkg::OP_CMP: ;
         rvmie_pkg::OP_JMP: begin isj = 1'b1; take = 1'b1; end
         rvmie_pkg::OP_JE:  begin isj = 1'b1; take = zc; end
         rvmie_pkg::OP_JNE: begin isj = 1'b1; take = !zc; end
         rvmie_pkg::OP_JG:  begin isj = 1'b1; take = !nc && !zc; end
         rvmie_pkg::OP_JL:  begin isj = 1'b1; take = nc; end
         rvmie_pkg::OP_JGE: begin isj = 1'b1; take = !nc; end
         rvmie_pkg::OP_JLE: begin isj = 1'b1; take = nc || zc; end
         default: begin err = rvmie_pkg::ERR_OPCODE; npc = pc_ff; end
      endcase
      if (isj && take) npc = lab_rd;
      if (cmd_ff) begin
         npc = pc_ff; wen = 1'b0; err = rvmie_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         cmp_ff <= '0;
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= '0;
      end else if (ctrl.commit) begin
         pc_ff <= npc;
         if (wen) regs_ff[r0] <= wval;
         if (!cmd_ff && op_ff == rvmie_pkg::OP_CMP) cmp_ff <= d_ff - a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         next_pc    <= 10'(npc);
         halted     <= !cmd_ff && op_ff == rvmie_pkg::OP_HLT;
         out_valid  <= !cmd_ff && op_ff == rvmie_pkg::OP_OUT;
         out_value  <= (!cmd_ff && op_ff == rvmie_pkg::OP_OUT) ? 32'(d_ff) : '0;
         error_code <= err;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.commit && stat.is_div && !stat.div_zero |-> !dbusy_ff || dk_ff == '0)
      else $error("Divide result used before it is complete.");
   assert property (@(posedge clock) disable iff (reset)
      !clearing |-> !(mem_we && lwe)) else $error("Data and label writes in one commit.");
   assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> (halted |-> next_pc == $past(pc_ff)))
      else $error("Halt moved the program counter.");
endmodule

FILE: hdl/register_vm_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// register_vm_instruction_execute_top
// Executes one register machine instruction, or writes a label entry, per item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req     | in        | instruction or label write
//  rsp     | out       | next pc, halt, output value, error
//
// An item passes through operand read, a data memory read for ld and st, a
// wait on the bit-serial divider for div (cut short on a divide by zero),
// commit and output before the next item is accepted. After reset a clearing
// pass over max(DATA_WORDS, LABEL_COUNT) addresses zeroes data memory and the
// label table before the first item is taken.
// A stalled response holds the block; the next item waits until it is taken.
module register_vm_instruction_execute_top #(
   parameter int REG_COUNT   = 16,
   parameter int DATA_WORDS  = 1024,
   parameter int CODE_WORDS  = 1024,
   parameter int LABEL_COUNT = 256,
   parameter int WORD_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command
   input  logic         req_tuser,
   // opcode, dest_or_label, src_is_const, second_operand, third_is_reg,
   // third_operand, input_value, label_id, label_target, pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_pc, halted, out_valid, out_value, error_code, pad
   output logic [47:0]  rsp_tdata
);
   localparam int CLEAR = (DATA_WORDS > LABEL_COUNT) ? DATA_WORDS : LABEL_COUNT;
   localparam int CLB   = $clog2(CLEAR);

   rvmie_pkg::ctrl_type ctrl;
   rvmie_pkg::stat_type stat;
   logic                clearing;
   logic [CLB-1:0]      clear_addr;
   logic [9:0]          next_pc;
   logic                halted, out_valid;
   logic [31:0]         out_value;
   logic [1:0]          error_code;

   rvmie_ctrl #(.CLEAR_CYCLES(CLEAR)) u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .stat(stat), .ctrl(ctrl),
      .clearing(clearing), .clear_addr(clear_addr));

   rvmie_dp #(
      .REG_COUNT(REG_COUNT), .DATA_WORDS(DATA_WORDS), .CODE_WORDS(CODE_WORDS),
      .LABEL_COUNT(LABEL_COUNT), .WORD_BITS(WORD_BITS), .CLR_BITS(CLB)
   ) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .clearing(clearing), .clear_addr(clear_addr),
      .command(req_tuser), .opcode(req_tdata[4:0]), .dest_or_label(req_tdata[12:5]),
      .src_is_const(req_tdata[13]), .second_operand(req_tdata[45:14]),
      .third_is_reg(req_tdata[46]), .third_operand(req_tdata[50:47]),
      .input_value(req_tdata[82:51]), .label_id(req_tdata[90:83]),
      .label_target(req_tdata[100:91]),
      .next_pc(next_pc), .halted(halted), .out_valid(out_valid),
      .out_value(out_value), .error_code(error_code));

   assign rsp_tdata = {2'd0, error_code, out_value, out_valid, halted, next_pc};
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the register machine instruction executor. Instructions and
// label writes are streamed in, and a local model of the machine state
// predicts each response, which is compared field by field on arrival.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic        command;
      logic [4:0]  opcode;
      logic [7:0]  dest_or_label;
      logic        src_is_const;
      logic [31:0] second_operand;
      logic        third_is_reg;
      logic [3:0]  third_operand;
      logic [31:0] input_value;
      logic [7:0]  label_id;
      logic [9:0]  label_target;
   } instr_type;

   typedef struct {
      logic [9:0]  next_pc;
      logic        halted;
      logic        out_valid;
      logic [31:0] out_value;
      logic [1:0]  error_code;
   } outcome_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;

   logic [9:0]  mach_pc;
   logic [31:0] mach_regs [16];
   logic [31:0] mach_cmp;
   logic [31:0] mach_mem [1024];
   logic [9:0]  mach_labels [256];

   outcome_type pending_outcomes [$];
   int       failures = 0;
   int       cycle_count = 0;
   bit       no_idle = 1'b0;
   int       hold_requests = 0;

   register_vm_instruction_execute_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic outcome_type execute_instr(instr_type it);
      outcome_type o;
      logic [3:0]  r0, r1, r2;
      logic [31:0] a, b, addr;
      logic        take, is_jump;
      o = '{next_pc: mach_pc, halted: 1'b0, out_valid: 1'b0, out_value: '0,
            error_code: rvmie_pkg::ERR_NONE};
      if (it.command) begin
         mach_labels[it.label_id] = it.label_target;
         return o;
      end
      r0 = it.dest_or_label[3:0];
      r1 = it.second_operand[3:0];
      r2 = it.third_operand;
      a = mach_regs[r1];
      b = mach_regs[r2];
      take = 1'b0;
      is_jump = 1'b0;
      o.next_pc = mach_pc + 10'd1;
      case (it.opcode)
         rvmie_pkg::OP_HLT: begin
            o.halted = 1'b1;
            o.next_pc = mach_pc;
         end
         rvmie_pkg::OP_MOV: mach_regs[r0] = it.src_is_const ? it.second_operand : a;
         rvmie_pkg::OP_ST, rvmie_pkg::OP_LD: begin
            addr = it.third_is_reg ? a + b : a;
            if (it.opcode == rvmie_pkg::OP_ST) mach_mem[addr[9:0]] = mach_regs[r0];
            else mach_regs[r0] = mach_mem[addr[9:0]];
         end
         rvmie_pkg::OP_ADD: mach_regs[r0] = a + b;
         rvmie_pkg::OP_SUB: mach_regs[r0] = a - b;
         rvmie_pkg::OP_MUL: mach_regs[r0] = a * b;
         rvmie_pkg::OP_DIV: begin
            if (b == 0) begin
               o.error_code = rvmie_pkg::ERR_DIVZ;
               o.next_pc = mach_pc;
            end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
               mach_regs[r0] = a;
            end else begin
               mach_regs[r0] = $signed(a) / $signed(b);
            end
         end
         rvmie_pkg::OP_INC: mach_regs[r0] = mach_regs[r0] + 32'd1;
         rvmie_pkg::OP_DEC: mach_regs[r0] = mach_regs[r0] - 32'd1;
         rvmie_pkg::OP_IN: mach_regs[r0] = it.input_value;
         rvmie_pkg::OP_OUT: begin
            o.out_valid = 1'b1;
            o.out_value = mach_regs[r0];
         end
         rvmie_pkg::OP_POP, rvmie_pkg::OP_PUSH: ;
         rvmie_pkg::OP_CMP: mach_cmp = mach_regs[r0] - a;
         rvmie_pkg::OP_JMP: begin is_jump = 1'b1; take = 1'b1; end
         rvmie_pkg::OP_JE: begin is_jump = 1'b1; take = (mach_cmp == 0); end
         rvmie_pkg::OP_JNE: begin is_jump = 1'b1; take = (mach_cmp != 0); end
         rvmie_pkg::OP_JG: begin is_jump = 1'b1; take = ($signed(mach_cmp) > 0); end
         rvmie_pkg::OP_JL: begin is_jump = 1'b1; take = ($signed(mach_cmp) < 0); end
         rvmie_pkg::OP_JGE: begin is_jump = 1'b1; take = ($signed(mach_cmp) >= 0); end
         rvmie_pkg::OP_JLE: begin is_jump = 1'b1; take = ($signed(mach_cmp) <= 0); end
         default: begin
            o.error_code = rvmie_pkg::ERR_OPCODE;
            o.next_pc = mach_pc;
         end
      endcase
      if (is_jump && take) o.next_pc = mach_labels[it.dest_or_label];
      mach_pc = o.next_pc;
      return o;
   endfunction

   task automatic send_instr(instr_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {3'b000, it.label_target, it.label_id, it.input_value, it.third_operand,
                    it.third_is_reg, it.second_operand, it.src_is_const,
                    it.dest_or_label, it.opcode};
      req_tuser <= it.command;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(execute_instr(it));
   endtask

   function automatic instr_type make_instr(logic [4:0] op, logic [7:0] dest,
                                            logic [31:0] second, logic third_reg = 1'b0,
                                            logic [3:0] third = '0, logic src_const = 1'b0,
                                            logic [31:0] in_val = '0);
      instr_type it;
      it = '{command: 1'b0, opcode: op, dest_or_label: dest, src_is_const: src_const,
             second_operand: second, third_is_reg: third_reg, third_operand: third,
             input_value: in_val, label_id: '0, label_target: '0};
      return it;
   endfunction

   function automatic instr_type make_label(logic [7:0] id, logic [9:0] target);
      instr_type it;
      it = make_instr(rvmie_pkg::OP_HLT, 8'hFF, '1, 1'b1, 4'hF, 1'b1, '1);
      it.command = 1'b1;
      it.label_id = id;
      it.label_target = target;
      return it;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 40);
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return -$urandom_range(0, 40);
      endcase
   endfunction

   function automatic instr_type random_instr();
      instr_type it;
      it.command = ($urandom_range(0, 11) == 0);
      it.opcode = ($urandom_range(0, 24) == 0)
                  ? 5'($urandom_range(rvmie_pkg::OP_JLE + 1, 31))
                  : 5'($urandom_range(rvmie_pkg::OP_HLT, rvmie_pkg::OP_JLE));
      it.dest_or_label = 8'($urandom);
      it.src_is_const = 1'($urandom);
      it.second_operand = it.src_is_const ? pick_value() : 32'($urandom);
      it.third_is_reg = 1'($urandom);
      it.third_operand = 4'($urandom);
      it.input_value = pick_value();
      it.label_id = 8'($urandom);
      it.label_target = 10'($urandom);
      if (it.opcode >= rvmie_pkg::OP_JMP && $urandom_range(0, 1)) it.dest_or_label[7:3] = '0;
      if (it.command && $urandom_range(0, 1)) it.label_id[7:3] = '0;
      return it;
   endfunction

   initial begin
      int stall;
      int holds_done;
      holds_done = 0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (hold_requests > holds_done) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            holds_done++;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_outcome();
      end
   end

   task automatic check_outcome();
      outcome_type e;
      if (pending_outcomes.size() == 0) begin
         $error("Response transfer with no instruction outstanding");
         failures++;
         return;
      end
      e = pending_outcomes.pop_front();
      if (rsp_tdata[9:0] !== e.next_pc) begin
         $error("next_pc expected %0d actual %0d", e.next_pc, rsp_tdata[9:0]);
         failures++;
      end
      if (rsp_tdata[10] !== e.halted) begin
         $error("halted expected %0d actual %0d", e.halted, rsp_tdata[10]);
         failures++;
      end
      if (rsp_tdata[11] !== e.out_valid) begin
         $error("out_valid expected %0d actual %0d", e.out_valid, rsp_tdata[11]);
         failures++;
      end
      if (rsp_tdata[43:12] !== e.out_value) begin
         $error("out_value expected %h actual %h", e.out_value, rsp_tdata[43:12]);
         failures++;
      end
      if (rsp_tdata[45:44] !== e.error_code) begin
         $error("error_code expected %0d actual %0d", e.error_code, rsp_tdata[45:44]);
         failures++;
      end
   endtask

   task automatic test_directed();
      send_instr(make_label(8'd0, 10'd1023));
      send_instr(make_label(8'd255, 10'd0));
      send_instr(make_label(8'd7, 10'd512));
      send_instr(make_instr(rvmie_pkg::OP_MOV, 8'd1, 32'h7FFF_FFFF, 1'b0, 4'd0, 1'b1));
      send_instr(make_instr(rvmie_pkg::OP_MOV, 8'd2, 32'h8000_0000, 1'b0, 4'd0, 1'b1));
      send_instr(make_instr(rvmie_pkg::OP_MOV, 8'd3, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b1));
      send_instr(make_instr(rvmie_pkg::OP_MOV, 8'hF4, 32'hFFFF_FFF1));
      send_instr(make_instr(rvmie_pkg::OP_ADD, 8'd5, 32'd1, 1'b0, 4'd1));
      send_instr(make_instr(rvmie_pkg::OP_SUB, 8'd6, 32'd2, 1'b0, 4'd1));
      send_instr(make_instr(rvmie_pkg::OP_MUL, 8'd7, 32'd1, 1'b0, 4'd1));
      send_instr(make_instr(rvmie_pkg::OP_DIV, 8'd8, 32'd2, 1'b0, 4'd3));
      send_instr(make_instr(rvmie_pkg::OP_DIV, 8'd8, 32'd2, 1'b0, 4'd0));
      send_instr(make_instr(rvmie_pkg::OP_DIV, 8'd9, 32'd1, 1'b0, 4'd2));
      send_instr(make_instr(rvmie_pkg::OP_INC, 8'd1, '0));
      send_instr(make_instr(rvmie_pkg::OP_DEC, 8'd0, '0));
      send_instr(make_instr(rvmie_pkg::OP_IN, 8'd10, '0, 1'b0, 4'd0, 1'b0, 32'h8000_0001));
      send_instr(make_instr(rvmie_pkg::OP_ST, 8'd10, 32'd3, 1'b1, 4'd1));
      send_instr(make_instr(rvmie_pkg::OP_LD, 8'd11, 32'd3, 1'b1, 4'd1));
      send_instr(make_instr(rvmie_pkg::OP_OUT, 8'd11, '0));
      send_instr(make_instr(rvmie_pkg::OP_POP, 8'd1, '0));
      send_instr(make_instr(rvmie_pkg::OP_PUSH, 8'd1, '0));
      send_instr(make_instr(rvmie_pkg::OP_CMP, 8'd2, 32'd1));
      for (int op = rvmie_pkg::OP_JMP; op <= rvmie_pkg::OP_JLE; op++) begin
         send_instr(make_instr(5'(op), 8'd7, '0));
      end
      send_instr(make_instr(rvmie_pkg::OP_HLT, 8'd0, '0));
      send_instr(make_instr(5'(rvmie_pkg::OP_JLE + 1), 8'd0, '0));
      send_instr(make_instr(5'h1F, 8'd0, '0));
   endtask

   task automatic test_random(int count);
      repeat (count) send_instr(random_instr());
   endtask

   task automatic test_back_pressure();
      hold_requests++;
      repeat (40) send_instr(random_instr());
   endtask

   task automatic test_full_rate();
      no_idle = 1'b1;
      repeat (200) send_instr(random_instr());
      no_idle = 1'b0;
   endtask

   initial begin
      mach_pc = '0;
      mach_cmp = '0;
      foreach (mach_regs[i]) mach_regs[i] = '0;
      foreach (mach_mem[i]) mach_mem[i] = '0;
      foreach (mach_labels[i]) mach_labels[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_back_pressure();
      test_full_rate();
      test_random(560);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
